// File: design/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Types, codes and reset values shared by the countdown timer controller.
// ----------------------------------------------------------------------------
package cdt_pkg;

  typedef enum logic [2:0] {
    MODE_WELCOME = 3'd0,
    MODE_SET     = 3'd1,
    MODE_COUNT   = 3'd2,
    MODE_PAUSE   = 3'd3,
    MODE_ALARM   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    DISP_TIME      = 3'd0,
    DISP_WELCOME   = 3'd1,
    DISP_ALARM_UP  = 3'd2,
    DISP_DASHES    = 3'd3,
    DISP_ALARM_LOW = 3'd4
  } disp_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_ARM_1S  = 3'd1,
    CMD_ARM_REP = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PRESET_MIN  = 2'd0,
    REG_WELCOME_TCK = 2'd1,
    REG_BLINK_START = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [6:0]  PresetMinRst  = 7'd45;
  localparam logic [7:0]  WelcomeTckRst = 8'd1;
  localparam logic [15:0] BlinkStartRst = 16'd10;

  localparam logic [6:0] MinutesMax = 7'd99;
  localparam logic [5:0] SecondsMax = 6'd59;
  localparam logic [3:0] MinTensTop = 4'd9;
  localparam logic [3:0] SecTensTop = 4'd5;
  localparam logic [3:0] UnitsTop   = 4'd9;

  // tens digit of a value below 128, by reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] v);
    logic [6:0] r;
    r = v - 7'(tens_of(v)) * 7'd10;
    return r[3:0];
  endfunction

  function automatic logic [3:0] bump_digit(input logic [3:0] d, input logic [3:0] top);
    return (d >= top) ? 4'd0 : d + 4'd1;
  endfunction

endpackage

// File: design/countdown_timer_mmss_controller_unit.sv
// ----------------------------------------------------------------------------
// countdown_timer_mmss_controller_unit
// Kitchen timer mode controller: welcome, set, counting, paused and alarm.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                        tuser
//  s_axis    in   7 button flags               tick_event, button_event
//  m_axis    out  mode..timer_command (23 b)   -
//  cfg       in   write enable, index, data    -
//
//  one beat per cycle sustained while m_axis is ready; a taken beat passes the
//  input register, then the result register with the mode state update
//  reset puts the block in welcome with preset 45 minutes, welcome count 1
//  and blink start 10
//  a stalled result holds; s_axis keeps taking beats while the result
//  register is free or being drained
module countdown_timer_mmss_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] min_tens_pressed [1] min_units_pressed [2] sec_tens_pressed
  // [3] sec_units_pressed [4] play_short [5] stop_short [6] stop_long
  input  logic [7:0]  s_axis_tdata,
  // [0] tick_event [1] button_event
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode [9:3] minutes [15:10] seconds [16] colon_on
  // [19:17] display_code [22:20] timer_command
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [cdt_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [6:0]  preset_q;
  logic [7:0]  welcome_tck_q;
  logic [15:0] blink_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q      <= cdt_pkg::PresetMinRst;
      welcome_tck_q <= cdt_pkg::WelcomeTckRst;
      blink_start_q <= cdt_pkg::BlinkStartRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cdt_pkg::REG_PRESET_MIN:  preset_q      <= cfg_data_i[6:0];
        cdt_pkg::REG_WELCOME_TCK: welcome_tck_q <= cfg_data_i[7:0];
        cdt_pkg::REG_BLINK_START: blink_start_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic [1:0] in_user_q;
  logic       advance;
  logic       out_valid_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // mode state
  cdt_pkg::mode_e mode_q, mode_d;
  cdt_pkg::disp_e disp_q, disp_d;
  cdt_pkg::cmd_e  cmd_d;
  logic [6:0]  minutes_q, minutes_d;
  logic [5:0]  seconds_q, seconds_d;
  logic        colon_q, colon_d;
  logic [7:0]  wcount_q, wcount_d;
  logic [15:0] blink_q, blink_d;

  logic tick, btn, b_mt, b_mu, b_st, b_su, play, stop_s, stop_l;
  logic [6:0] preset_clamped;
  logic [6:0] min_bumped;
  logic [5:0] sec_bumped;
  logic [3:0] mt, mu, st, su;
  logic [15:0] blink_dec;

  assign tick   = in_user_q[0];
  assign btn    = in_user_q[1];
  assign b_mt   = btn && in_data_q[0];
  assign b_mu   = btn && in_data_q[1];
  assign b_st   = btn && in_data_q[2];
  assign b_su   = btn && in_data_q[3];
  assign play   = btn && in_data_q[4];
  assign stop_s = btn && in_data_q[5];
  assign stop_l = btn && in_data_q[6];

  assign preset_clamped = (preset_q > cdt_pkg::MinutesMax) ? cdt_pkg::MinutesMax : preset_q;
  assign blink_dec      = blink_q - 16'd1;

  // tens and units digits change independently
  always_comb begin
    mt = cdt_pkg::tens_of(minutes_q);
    mu = cdt_pkg::units_of(minutes_q);
    st = cdt_pkg::tens_of({1'b0, seconds_q});
    su = cdt_pkg::units_of({1'b0, seconds_q});
    if (b_mt) mt = cdt_pkg::bump_digit(mt, cdt_pkg::MinTensTop);
    if (b_mu) mu = cdt_pkg::bump_digit(mu, cdt_pkg::UnitsTop);
    if (b_st) st = cdt_pkg::bump_digit(st, cdt_pkg::SecTensTop);
    if (b_su) su = cdt_pkg::bump_digit(su, cdt_pkg::UnitsTop);
    min_bumped = 7'(mt) * 7'd10 + 7'(mu);
    sec_bumped = 6'(st) * 6'd10 + 6'(su);
  end

  always_comb begin
    mode_d    = mode_q;
    disp_d    = disp_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    colon_d   = colon_q;
    wcount_d  = wcount_q;
    blink_d   = blink_q;
    cmd_d     = cdt_pkg::CMD_NONE;
    unique case (mode_q)
      cdt_pkg::MODE_WELCOME: begin
        if (tick) begin
          if (wcount_q == 8'd0) begin
            mode_d = cdt_pkg::MODE_SET;
            disp_d = cdt_pkg::DISP_TIME;
          end else begin
            wcount_d = wcount_q - 8'd1;
            cmd_d    = cdt_pkg::CMD_ARM_1S;
          end
        end
        if (btn) begin
          mode_d = cdt_pkg::MODE_SET;
          disp_d = cdt_pkg::DISP_TIME;
          cmd_d  = cdt_pkg::CMD_CANCEL;
        end
      end
      cdt_pkg::MODE_SET: begin
        if (btn) begin
          minutes_d = min_bumped;
          seconds_d = sec_bumped;
          if (play) begin
            colon_d = 1'b1;
            mode_d  = cdt_pkg::MODE_COUNT;
            cmd_d   = cdt_pkg::CMD_ARM_REP;
          end
          if (stop_l) begin
            minutes_d = 7'd0;
            seconds_d = 6'd0;
            colon_d   = 1'b1;
          end
          disp_d = cdt_pkg::DISP_TIME;
        end
      end
      cdt_pkg::MODE_COUNT: begin
        if (tick) begin
          colon_d = !colon_q;
          // a full second passes on the colon's rising phase
          if (!colon_q) begin
            if (seconds_q != 6'd0) begin
              seconds_d = seconds_q - 6'd1;
            end else if (minutes_q != 7'd0) begin
              seconds_d = cdt_pkg::SecondsMax;
              minutes_d = minutes_q - 7'd1;
            end else begin
              blink_d = blink_start_q;
              mode_d  = cdt_pkg::MODE_ALARM;
              disp_d  = cdt_pkg::DISP_ALARM_UP;
            end
          end
        end
        if (play) begin
          mode_d = cdt_pkg::MODE_PAUSE;
          cmd_d  = cdt_pkg::CMD_CANCEL;
        end
      end
      cdt_pkg::MODE_PAUSE: begin
        if (play) begin
          mode_d = cdt_pkg::MODE_COUNT;
          cmd_d  = cdt_pkg::CMD_ARM_REP;
        end
      end
      cdt_pkg::MODE_ALARM: begin
        if (tick) begin
          blink_d = blink_dec;
          disp_d  = blink_dec[0] ? cdt_pkg::DISP_DASHES : cdt_pkg::DISP_ALARM_LOW;
        end
      end
      default: ;
    endcase
    // restart wins over everything else in the beat
    if ((stop_l && (mode_q == cdt_pkg::MODE_COUNT || mode_q == cdt_pkg::MODE_PAUSE)) ||
        ((stop_s || stop_l) && mode_q == cdt_pkg::MODE_ALARM)) begin
      mode_d    = cdt_pkg::MODE_WELCOME;
      disp_d    = cdt_pkg::DISP_WELCOME;
      minutes_d = preset_clamped;
      seconds_d = 6'd0;
      colon_d   = 1'b1;
      wcount_d  = welcome_tck_q;
      cmd_d     = cdt_pkg::CMD_RESTART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cdt_pkg::MODE_WELCOME;
      disp_q    <= cdt_pkg::DISP_WELCOME;
      minutes_q <= cdt_pkg::PresetMinRst;
      seconds_q <= 6'd0;
      colon_q   <= 1'b1;
      wcount_q  <= cdt_pkg::WelcomeTckRst;
      blink_q   <= 16'd0;
    end else if (advance) begin
      mode_q    <= mode_d;
      disp_q    <= disp_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      colon_q   <= colon_d;
      wcount_q  <= wcount_d;
      blink_q   <= blink_d;
    end
  end

  // result register
  logic [23:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, cmd_d, disp_d, colon_d, seconds_d, minutes_d, mode_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minutes_q <= cdt_pkg::MinutesMax)
    else $error("minutes out of range");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seconds_q <= cdt_pkg::SecondsMax)
    else $error("seconds out of range");

  a_restart_welcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_d == cdt_pkg::CMD_RESTART |=> mode_q == cdt_pkg::MODE_WELCOME)
    else $error("restart did not return to welcome");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q) && $stable(in_user_q))
    else $error("pending beat lost");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && mode_q == cdt_pkg::MODE_COUNT && !tick && !btn |=>
      $stable(seconds_q) && $stable(minutes_q) && $stable(colon_q))
    else $error("count moved without a tick");

endmodule
